FILE: rtl/assert_macros.svh
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, quiet while reset is high.
`define ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, quiet while reset is high.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

// Next-cycle implication that also holds across reset.
`define ASSERT_NEXT_ALWAYS(label, clk, ante, cons, msg) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/tmig_pkg.sv
`default_nettype none

package tmig_pkg;

  localparam int unsigned MAX_RINGS        = 1024;
  localparam int unsigned MAX_DETAIL       = 1024;
  localparam int unsigned SINE_TABLE_DEPTH = 256;
  localparam int unsigned QUEUE_DEPTH      = 4;

  localparam int unsigned IDX_W   = 10;
  localparam int unsigned CNT_W   = 11;
  localparam int unsigned PHASE_W = 16;
  localparam int unsigned Q88_W   = 16;
  localparam int unsigned SIN_W   = 16;
  localparam int unsigned POS_W   = 19;
  localparam int unsigned TEX_W   = 18;
  localparam int unsigned VN_W    = 20;
  localparam int unsigned ADDR_W  = 5;
  localparam int unsigned DATA_W  = 32;

  localparam int unsigned SIN_IDX_W  = $clog2(SINE_TABLE_DEPTH);
  localparam int unsigned SIN_PROD_W = 14 + $clog2(SINE_TABLE_DEPTH + 1);

  localparam logic [CNT_W-1:0] RING_MAX   = CNT_W'(MAX_RINGS);
  localparam logic [CNT_W-1:0] DETAIL_MAX = CNT_W'(MAX_DETAIL);
  localparam logic [14:0]      ONE_Q14    = 15'd16384;
  localparam logic [63:0]      HALF_PI_Q30 = 64'd1686629713;

  typedef enum logic [2:0] {
    REG_RING_COUNT     = 3'd0,
    REG_RING_DETAIL    = 3'd1,
    REG_RING_RADIUS    = 3'd2,
    REG_RING_THICKNESS = 3'd3,
    REG_THETA_STEP     = 3'd4,
    REG_PHI_STEP       = 3'd5
  } reg_idx_t;

  typedef struct packed {
    logic [CNT_W-1:0]   ring_count;
    logic [CNT_W-1:0]   ring_detail;
    logic [Q88_W-1:0]   ring_radius;
    logic [Q88_W-1:0]   ring_thickness;
    logic [PHASE_W-1:0] theta_step;
    logic [PHASE_W-1:0] phi_step;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    ring_count:     CNT_W'(16),
    ring_detail:    CNT_W'(16),
    ring_radius:    Q88_W'(256),
    ring_thickness: Q88_W'(64),
    theta_step:     PHASE_W'(4096),
    phi_step:       PHASE_W'(4096)
  };

  // One classified grid cell on its way from front to back.
  typedef struct packed {
    logic [IDX_W-1:0]   ring;
    logic [IDX_W-1:0]   ring_next;
    logic [IDX_W-1:0]   detail;
    logic [IDX_W-1:0]   detail_next;
    logic [CNT_W-1:0]   detail_count;
    logic [PHASE_W-1:0] theta;
    logic [PHASE_W-1:0] phi;
  } item_t;

  typedef logic [14:0] sine_word_t;
  typedef sine_word_t sine_tab_t [SINE_TABLE_DEPTH];

  function automatic logic [63:0] taylor_term(input logic [63:0] t, input logic [63:0] a);
    taylor_term = (((t * a) >> 30) * a) >> 30;
  endfunction

  // Quarter-wave sine in Q1.14, built at elaboration.
  function automatic sine_tab_t build_sine_tab();
    sine_tab_t         tab;
    logic [63:0]       a;
    logic [63:0]       t;
    logic signed [63:0] sum;
    for (int k = 0; k < SINE_TABLE_DEPTH; k++) begin
      a   = (64'(k) * HALF_PI_Q30) / SINE_TABLE_DEPTH;
      t   = a;
      sum = $signed(a);
      t   = taylor_term(t, a) / 64'd6;
      sum = sum - $signed(t);
      t   = taylor_term(t, a) / 64'd20;
      sum = sum + $signed(t);
      t   = taylor_term(t, a) / 64'd42;
      sum = sum - $signed(t);
      t   = taylor_term(t, a) / 64'd72;
      sum = sum + $signed(t);
      t   = taylor_term(t, a) / 64'd110;
      sum = sum - $signed(t);
      t   = taylor_term(t, a) / 64'd156;
      sum = sum + $signed(t);
      if (sum < 0) sum = '0;
      sum = (sum + 64'sd32768) >>> 16;
      if (sum > 64'sd16384) sum = 64'sd16384;
      tab[k] = sum[14:0];
    end
    return tab;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/torus_mesh_vertex_and_index_gen.sv
// Torus vertex and index generator.
// Input channel (in_valid / in_stall, ring_index, detail_index): one grid cell
// per beat. Output channel (out_valid / out_stall): one beat per cell with the
// rotated vertex (pos_x/y/z, Q10.8), texture coordinates tex_u/tex_v and the
// four corner indices of the two triangles anchored on the cell.
// Configuration is written over the APB port at byte address 4*i; write it
// only while no cell is in flight.
// Throughput: one cell per cycle while no finished beat is held by out_stall; the
// five-stage back end (table lookup, ring-plane multiply, rounding, rotation
// multiply, output register) has multiplier pairs in its first, second and fourth stages.
// With out_valid and out_stall both high the back end holds; the front keeps taking
// cells into a QUEUE_DEPTH-entry queue plus one front register, then raises in_stall.
// Reset clears all valids and the queue, and loads the register defaults
// (16 rings, 16 steps, radius 1.0, thickness 0.25, both steps 4096).
`default_nettype none

module torus_mesh_vertex_and_index_gen #(
  parameter int unsigned QUEUE_DEPTH = tmig_pkg::QUEUE_DEPTH
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [tmig_pkg::ADDR_W-1:0]        paddr,
  input  logic [tmig_pkg::DATA_W-1:0]        pwdata,
  output logic [tmig_pkg::DATA_W-1:0]        prdata,
  output logic                               pready,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [tmig_pkg::IDX_W-1:0]         ring_index,
  input  logic [tmig_pkg::IDX_W-1:0]         detail_index,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic signed [tmig_pkg::POS_W-1:0]  pos_x,
  output logic signed [tmig_pkg::POS_W-1:0]  pos_y,
  output logic signed [tmig_pkg::POS_W-1:0]  pos_z,
  output logic signed [tmig_pkg::TEX_W-1:0]  tex_u,
  output logic signed [tmig_pkg::TEX_W-1:0]  tex_v,
  output logic [tmig_pkg::VN_W-1:0]          vertex_number,
  output logic [tmig_pkg::VN_W-1:0]          corner_p,
  output logic [tmig_pkg::VN_W-1:0]          corner_q,
  output logic [tmig_pkg::VN_W-1:0]          corner_r
);
  import tmig_pkg::*;

  cfg_t     cfg;
  reg_idx_t reg_sel;
  logic     f_valid;
  item_t    f_item;
  logic     q_full;
  logic     q_empty;
  logic     q_pop;
  item_t    q_head;

  assign pready  = 1'b1;
  assign reg_sel = reg_idx_t'(paddr[ADDR_W-1:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= CFG_RESET;
    end else if (psel && penable && pwrite) begin
      case (reg_sel)
        REG_RING_COUNT:     cfg.ring_count     <= pwdata[CNT_W-1:0];
        REG_RING_DETAIL:    cfg.ring_detail    <= pwdata[CNT_W-1:0];
        REG_RING_RADIUS:    cfg.ring_radius    <= pwdata[Q88_W-1:0];
        REG_RING_THICKNESS: cfg.ring_thickness <= pwdata[Q88_W-1:0];
        REG_THETA_STEP:     cfg.theta_step     <= pwdata[PHASE_W-1:0];
        REG_PHI_STEP:       cfg.phi_step       <= pwdata[PHASE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      REG_RING_COUNT:     prdata = DATA_W'(cfg.ring_count);
      REG_RING_DETAIL:    prdata = DATA_W'(cfg.ring_detail);
      REG_RING_RADIUS:    prdata = DATA_W'(cfg.ring_radius);
      REG_RING_THICKNESS: prdata = DATA_W'(cfg.ring_thickness);
      REG_THETA_STEP:     prdata = DATA_W'(cfg.theta_step);
      REG_PHI_STEP:       prdata = DATA_W'(cfg.phi_step);
      default:            prdata = '0;
    endcase
  end

  tmig_front u_front (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .ring_index   (ring_index),
    .detail_index (detail_index),
    .cfg          (cfg),
    .q_full       (q_full),
    .f_valid      (f_valid),
    .f_item       (f_item)
  );

  tmig_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (f_valid),
    .push_item  (f_item),
    .full       (q_full),
    .pop        (q_pop),
    .empty      (q_empty),
    .head       (q_head)
  );

  tmig_back u_back (
    .clk           (clk),
    .rst           (rst),
    .cfg           (cfg),
    .q_empty       (q_empty),
    .q_head        (q_head),
    .q_pop         (q_pop),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .pos_x         (pos_x),
    .pos_y         (pos_y),
    .pos_z         (pos_z),
    .tex_u         (tex_u),
    .tex_v         (tex_v),
    .vertex_number (vertex_number),
    .corner_p      (corner_p),
    .corner_q      (corner_q),
    .corner_r      (corner_r)
  );

endmodule

`default_nettype wire

FILE: rtl/tmig_front.sv
`default_nettype none

module tmig_front (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [tmig_pkg::IDX_W-1:0]   ring_index,
  input  logic [tmig_pkg::IDX_W-1:0]   detail_index,
  input  tmig_pkg::cfg_t               cfg,
  input  logic                         q_full,
  output logic                         f_valid,
  output tmig_pkg::item_t              f_item
);
  import tmig_pkg::*;

  logic                     accept;
  logic [CNT_W-1:0]         rc;
  logic [CNT_W-1:0]         rd;
  logic [CNT_W-1:0]         rc_m1;
  logic [CNT_W-1:0]         rd_m1;
  logic [IDX_W-1:0]         ring_c;
  logic [IDX_W-1:0]         detail_c;
  logic [IDX_W+PHASE_W-1:0] theta_full;
  logic [IDX_W+PHASE_W-1:0] phi_full;
  item_t                    item_next;

  function automatic logic [CNT_W-1:0] eff_count(input logic [CNT_W-1:0] v,
                                                 input logic [CNT_W-1:0] maxv);
    if (v == '0) return CNT_W'(1);
    return (v > maxv) ? maxv : v;
  endfunction

  assign in_stall = f_valid && q_full;
  assign accept   = in_valid && !in_stall;

  always_comb begin
    rc    = eff_count(cfg.ring_count, RING_MAX);
    rd    = eff_count(cfg.ring_detail, DETAIL_MAX);
    rc_m1 = rc - CNT_W'(1);
    rd_m1 = rd - CNT_W'(1);
    // clamp indices past the last ring or step
    ring_c   = ({1'b0, ring_index} > rc_m1) ? rc_m1[IDX_W-1:0] : ring_index;
    detail_c = ({1'b0, detail_index} > rd_m1) ? rd_m1[IDX_W-1:0] : detail_index;
    theta_full = detail_c * cfg.theta_step;
    phi_full   = ring_c * cfg.phi_step;
    item_next.ring         = ring_c;
    item_next.ring_next    = ({1'b0, ring_c} == rc_m1) ? '0 : ring_c + IDX_W'(1);
    item_next.detail       = detail_c;
    item_next.detail_next  = ({1'b0, detail_c} == rd_m1) ? '0 : detail_c + IDX_W'(1);
    item_next.detail_count = rd;
    item_next.theta        = theta_full[PHASE_W-1:0];
    item_next.phi          = phi_full[PHASE_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      f_valid <= 1'b0;
    end else if (accept) begin
      f_valid <= 1'b1;
    end else if (!q_full) begin
      f_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      f_item <= item_next;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/tmig_queue.sv
`default_nettype none

module tmig_queue #(
  parameter int unsigned DEPTH = tmig_pkg::QUEUE_DEPTH
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            push_valid,
  input  tmig_pkg::item_t push_item,
  output logic            full,
  input  logic            pop,
  output logic            empty,
  output tmig_pkg::item_t head
);
  import tmig_pkg::*;

  localparam int unsigned PTR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned FILL_W = $clog2(DEPTH + 1);

  item_t             mem [DEPTH];
  logic [PTR_W-1:0]  wr_ptr;
  logic [PTR_W-1:0]  rd_ptr;
  logic [FILL_W-1:0] fill;
  logic              push;
  logic              pop_ok;

  function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
  endfunction

  assign full   = (fill == FILL_W'(DEPTH));
  assign empty  = (fill == '0);
  assign push   = push_valid && !full;
  assign pop_ok = pop && !empty;
  assign head   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) wr_ptr <= next_ptr(wr_ptr);
      if (pop_ok) rd_ptr <= next_ptr(rd_ptr);
      if (push && !pop_ok) begin
        fill <= fill + FILL_W'(1);
      end else if (pop_ok && !push) begin
        fill <= fill - FILL_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_item;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/tmig_back.sv
`default_nettype none

module tmig_back (
  input  logic                               clk,
  input  logic                               rst,
  input  tmig_pkg::cfg_t                     cfg,
  input  logic                               q_empty,
  input  tmig_pkg::item_t                    q_head,
  output logic                               q_pop,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic signed [tmig_pkg::POS_W-1:0]  pos_x,
  output logic signed [tmig_pkg::POS_W-1:0]  pos_y,
  output logic signed [tmig_pkg::POS_W-1:0]  pos_z,
  output logic signed [tmig_pkg::TEX_W-1:0]  tex_u,
  output logic signed [tmig_pkg::TEX_W-1:0]  tex_v,
  output logic [tmig_pkg::VN_W-1:0]          vertex_number,
  output logic [tmig_pkg::VN_W-1:0]          corner_p,
  output logic [tmig_pkg::VN_W-1:0]          corner_q,
  output logic [tmig_pkg::VN_W-1:0]          corner_r
);
  import tmig_pkg::*;

  localparam sine_tab_t SINE_TAB = build_sine_tab();

  typedef struct packed {
    logic [VN_W-1:0] vn;
    logic [VN_W-1:0] cp;
    logic [VN_W-1:0] cq;
    logic [VN_W-1:0] cr;
  } corners_t;

  logic en;

  // stage 1: sine lookups, row bases
  logic                      v1;
  logic signed [SIN_W-1:0]   s1_s, s1_c, s1_sp, s1_cp;
  logic [VN_W-1:0]           s1_base_i, s1_base_n;
  logic [IDX_W-1:0]          s1_j, s1_jn;
  logic [IDX_W+CNT_W-1:0]    base_i_full, base_n_full;

  // stage 2: ring-plane products, corner sums
  logic                      v2;
  logic signed [33:0]        s2_mx, s2_my;
  logic signed [SIN_W-1:0]   s2_sp, s2_cp;
  corners_t                  s2_cn;
  logic signed [SIN_W:0]     c_minus_s, s_plus_c, thick_s;

  // stage 3: ring-plane point
  logic                      v3;
  logic signed [19:0]        s3_x;
  logic signed [POS_W-1:0]   s3_y;
  logic signed [SIN_W-1:0]   s3_sp, s3_cp;
  corners_t                  s3_cn;
  logic signed [33:0]        rx, ry;

  // stage 4: rotation products
  logic                      v4;
  logic signed [36:0]        s4_mpx, s4_mpz;
  logic signed [POS_W-1:0]   s4_y;
  corners_t                  s4_cn;
  logic signed [36:0]        prod_x, prod_z;

  logic signed [36:0]        rpx, rpz;
  logic signed [POS_W-1:0]   px_sat, pz_sat;

  function automatic logic signed [SIN_W-1:0] sin_q14(input logic [PHASE_W-1:0] p);
    logic [14:0]            g;
    logic [14:0]            mag;
    logic [SIN_PROD_W-1:0]  prod;
    g = p[14] ? (ONE_Q14 - {1'b0, p[13:0]}) : {1'b0, p[13:0]};
    prod = SIN_PROD_W'(g[13:0]) * SIN_PROD_W'(SINE_TABLE_DEPTH);
    mag = g[14] ? ONE_Q14 : SINE_TAB[prod[14 +: SIN_IDX_W]];
    return p[15] ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
  endfunction

  function automatic logic signed [POS_W-1:0] sat_pos(input logic signed [36:0] v);
    if (v > 37'sd262143) return POS_W'(262143);
    if (v < -37'sd262144) return POS_W'(-262144);
    return v[POS_W-1:0];
  endfunction

  // advance the whole back end unless a finished beat is held
  assign en    = !out_valid || !out_stall;
  assign q_pop = en && !q_empty;

  always_comb begin
    base_i_full = q_head.ring * q_head.detail_count;
    base_n_full = q_head.ring_next * q_head.detail_count;
    c_minus_s   = $signed({s1_c[SIN_W-1], s1_c}) - $signed({s1_s[SIN_W-1], s1_s});
    s_plus_c    = $signed({s1_s[SIN_W-1], s1_s}) + $signed({s1_c[SIN_W-1], s1_c});
    thick_s     = $signed({1'b0, cfg.ring_thickness});
    rx          = (s2_mx + 34'sd8192) >>> 14;
    ry          = (s2_my + 34'sd8192) >>> 14;
    prod_x      = s3_x * s3_sp;
    prod_z      = s3_x * s3_cp;
    rpx         = (s4_mpx + 37'sd8192) >>> 14;
    rpz         = (s4_mpz + 37'sd8192) >>> 14;
    px_sat      = sat_pos(rpx);
    pz_sat      = sat_pos(rpz);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      v3        <= 1'b0;
      v4        <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      v1        <= !q_empty;
      v2        <= v1;
      v3        <= v2;
      v4        <= v3;
      out_valid <= v4;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_s      <= sin_q14(q_head.theta);
      s1_c      <= sin_q14(q_head.theta + PHASE_W'(16384));
      s1_sp     <= sin_q14(q_head.phi);
      s1_cp     <= sin_q14(q_head.phi + PHASE_W'(16384));
      s1_base_i <= base_i_full[VN_W-1:0];
      s1_base_n <= base_n_full[VN_W-1:0];
      s1_j      <= q_head.detail;
      s1_jn     <= q_head.detail_next;

      s2_mx    <= c_minus_s * thick_s;
      s2_my    <= s_plus_c * thick_s;
      s2_sp    <= s1_sp;
      s2_cp    <= s1_cp;
      s2_cn.vn <= s1_base_i + VN_W'(s1_j);
      s2_cn.cp <= s1_base_i + VN_W'(s1_jn);
      s2_cn.cq <= s1_base_n + VN_W'(s1_jn);
      s2_cn.cr <= s1_base_n + VN_W'(s1_j);

      s3_x  <= $signed({4'b0, cfg.ring_radius}) + rx[19:0];
      s3_y  <= sat_pos(37'(ry));
      s3_sp <= s2_sp;
      s3_cp <= s2_cp;
      s3_cn <= s2_cn;

      s4_mpx <= -prod_x;
      s4_mpz <= prod_z;
      s4_y   <= s3_y;
      s4_cn  <= s3_cn;

      pos_x         <= px_sat;
      pos_y         <= s4_y;
      pos_z         <= pz_sat;
      tex_u         <= px_sat[POS_W-1:1];
      tex_v         <= pz_sat[POS_W-1:1];
      vertex_number <= s4_cn.vn;
      corner_p      <= s4_cn.cp;
      corner_q      <= s4_cn.cq;
      corner_r      <= s4_cn.cr;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/tmig_checker.sv
`default_nettype none
`include "assert_macros.svh"

module tmig_checker (
  input logic                               clk,
  input logic                               rst,
  input logic                               in_stall,
  input logic                               out_valid,
  input logic                               out_stall,
  input logic signed [tmig_pkg::POS_W-1:0]  pos_x,
  input logic signed [tmig_pkg::TEX_W-1:0]  tex_u,
  input logic [tmig_pkg::VN_W-1:0]          vertex_number,
  input logic [tmig_pkg::VN_W-1:0]          corner_p,
  input logic [tmig_pkg::VN_W-1:0]          corner_q,
  input logic [tmig_pkg::VN_W-1:0]          corner_r
);
  import tmig_pkg::*;

  // nothing is in flight right after reset
  `ASSERT_NEXT_ALWAYS(a_reset_idle, clk, rst, !out_valid && !in_stall, "not idle after reset")

  `ASSERT_NEXT(a_hold_on_stall, clk, rst, out_valid && out_stall, out_valid && $stable(pos_x) && $stable(vertex_number), "stalled beat changed")

  `ASSERT_IMPLY(a_tex_half, clk, rst, out_valid, tex_u == pos_x[POS_W-1:1], "tex_u is not half of pos_x")

  // both triangle edges across rings step by the same row offset
  `ASSERT_IMPLY(a_row_step, clk, rst, out_valid, VN_W'(corner_q - corner_p) == VN_W'(corner_r - vertex_number), "corner rows disagree")

endmodule

bind torus_mesh_vertex_and_index_gen tmig_checker u_tmig_checker (.*);

`default_nettype wire
